>>> rtl/core/sweep_vertex_event_classifier_defines.svh
// Assertion macros for the sweep vertex event classifier.
// Depends on nothing; the user must have clk and arst_n in scope.
`ifndef SWEEP_VERTEX_EVENT_CLASSIFIER_DEFINES_SVH
`define SWEEP_VERTEX_EVENT_CLASSIFIER_DEFINES_SVH

// Same-cycle implication, disabled while reset is held.
`define SVEC_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is held.
`define SVEC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/svec_pkg.sv
// Shared types, codes and the CORDIC arctangent table of the classifier.
// Depends on nothing.
package svec_pkg;

	localparam int COORD_BITS   = 16;
	localparam int XY_W         = COORD_BITS + 3;
	localparam int CORDIC_STEPS = 16;
	localparam int STEP_W       = $clog2(CORDIC_STEPS);
	localparam int ACC_FRAC     = 16;
	localparam int ACC_W        = 27;

	localparam logic signed [ACC_W-1:0] Z90  = ACC_W'(90 << ACC_FRAC);
	localparam logic signed [ACC_W-1:0] Z360 = ACC_W'(360 << ACC_FRAC);

	localparam logic [2:0] EV_NONE     = 3'd0;
	localparam logic [2:0] EV_IN       = 3'd1;
	localparam logic [2:0] EV_SIDE_IN  = 3'd2;
	localparam logic [2:0] EV_OUT      = 3'd3;
	localparam logic [2:0] EV_SIDE_OUT = 3'd4;
	localparam logic [2:0] EV_FLOOR    = 3'd5;
	localparam logic [2:0] EV_CEILING  = 3'd6;

	localparam logic [1:0] SRC_NONE     = 2'd0;
	localparam logic [1:0] SRC_INCOMING = 2'd1;
	localparam logic [1:0] SRC_OUTGOING = 2'd2;

	localparam logic [1:0] LOC_NONE    = 2'd0;
	localparam logic [1:0] LOC_OPENING = 2'd1;
	localparam logic [1:0] LOC_CLOSING = 2'd2;

	typedef struct packed {
		logic signed [COORD_BITS-1:0] in_dx;
		logic signed [COORD_BITS-1:0] in_dy;
		logic signed [COORD_BITS-1:0] out_dx;
		logic signed [COORD_BITS-1:0] out_dy;
		logic                         is_boundary;
		logic                         is_leftmost;
	} svec_in_t;

	typedef struct packed {
		logic [2:0] event_kind;
		logic [1:0] floor_source;
		logic [1:0] ceiling_source;
		logic       from_boundary;
	} svec_out_t;

	typedef struct packed {
		logic              load_first;
		logic              load_second;
		logic              iter;
		logic [STEP_W-1:0] step;
		logic              fin_first;
		logic              fin_second;
		logic              classify;
	} svec_cmd_t;

	// atan(2^-i) in degrees, 16 fraction bits
	function automatic logic signed [ACC_W-1:0] svec_atan(input logic [STEP_W-1:0] i);
		logic signed [ACC_W-1:0] v;
		case (i)
			4'd0:    v = ACC_W'(2949120);
			4'd1:    v = ACC_W'(1740967);
			4'd2:    v = ACC_W'(919879);
			4'd3:    v = ACC_W'(466945);
			4'd4:    v = ACC_W'(234379);
			4'd5:    v = ACC_W'(117304);
			4'd6:    v = ACC_W'(58666);
			4'd7:    v = ACC_W'(29335);
			4'd8:    v = ACC_W'(14668);
			4'd9:    v = ACC_W'(7334);
			4'd10:   v = ACC_W'(3667);
			4'd11:   v = ACC_W'(1833);
			4'd12:   v = ACC_W'(917);
			4'd13:   v = ACC_W'(458);
			4'd14:   v = ACC_W'(229);
			4'd15:   v = ACC_W'(115);
			default: v = '0;
		endcase
		return v;
	endfunction

endpackage

>>> rtl/core/sweep_vertex_event_classifier.sv
// Sweep vertex event classifier top level: svec_ctrl sequencer and svec_dp datapath.
// The result is registered after the vertex transaction passes two 16-step CORDIC
// runs on one shared unit, each followed by a finish step, and then a classify step.
// Vertices are not overlapped; a waiting result holds only the classify step.
// Reset (arst_n low): no result pending, sequencer idle, no opening/closing seen.
// Depends on svec_pkg and sweep_vertex_event_classifier_defines.svh.
`include "sweep_vertex_event_classifier_defines.svh"

module sweep_vertex_event_classifier
	import svec_pkg::*;
#(
	parameter int ANGLE_FRAC_BITS = 6
) (
	input  logic      clk,
	input  logic      arst_n,
	// vertex channel
	input  logic      vtx_valid,
	output logic      vtx_stall,
	input  svec_in_t  vtx,
	// event channel
	output logic      evt_valid,
	input  logic      evt_stall,
	output svec_out_t evt
);

	// Commands from the sequencer to the datapath. The sequencer loads the
	// incoming edge vector with the vertex transaction, steps the CORDIC unit,
	// finishes the incoming angle while loading the outgoing vector, steps
	// again, finishes the outgoing angle, then classifies once the event
	// register is free or being drained in that same cycle.
	svec_cmd_t cmd;

	svec_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx_valid (vtx_valid),
		.vtx_stall (vtx_stall),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.cmd       (cmd)
	);

	// The datapath holds the vertex, the CORDIC x/y/z registers, both angles,
	// the opening/closing history and the event register that drives evt.
	svec_dp #(
		.ANGLE_FRAC_BITS (ANGLE_FRAC_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (cmd),
		.vtx    (vtx),
		.evt    (evt)
	);

	// A vertex transaction must start a busy period.
	`SVEC_ASSERT_NEXT(a_busy_after_accept, vtx_valid && !vtx_stall, vtx_stall, "vertex accepted while idle did not go busy")
	// A new event only appears at the end of a busy period.
	`SVEC_ASSERT_NOW(a_event_from_busy, $rose(evt_valid), $past(vtx_stall), "event appeared without a vertex in work")
	// An event never follows its vertex in the very next cycle.
	`SVEC_ASSERT_NEXT(a_no_early_event, vtx_valid && !vtx_stall, !$rose(evt_valid), "event raised one cycle after vertex")
	// While a vertex is in work, a stalled event register must not reload.
	`SVEC_ASSERT_NEXT(a_hold_under_stall, evt_valid && evt_stall && vtx_stall, $stable(evt), "pending event overwritten by classification")

endmodule

>>> rtl/core/svec_ctrl.sv
// Sequencer of the classifier: handshakes and CORDIC step count.
// Depends on svec_pkg for the command type and step constants.
module svec_ctrl
	import svec_pkg::*;
(
	input  logic      clk,
	input  logic      arst_n,
	input  logic      vtx_valid,
	output logic      vtx_stall,
	output logic      evt_valid,
	input  logic      evt_stall,
	output svec_cmd_t cmd
);

	localparam logic [2:0] S_IDLE  = 3'd0;
	localparam logic [2:0] S_ITER1 = 3'd1;
	localparam logic [2:0] S_FIN1  = 3'd2;
	localparam logic [2:0] S_ITER2 = 3'd3;
	localparam logic [2:0] S_FIN2  = 3'd4;
	localparam logic [2:0] S_CLASS = 3'd5;

	localparam logic [STEP_W-1:0] LAST_STEP = STEP_W'(CORDIC_STEPS - 1);

	logic [2:0]        state_q, state_d;
	logic [STEP_W-1:0] step_q;
	logic              evt_valid_q;
	logic              slot_free;

	assign slot_free = !evt_valid_q || !evt_stall;
	assign vtx_stall = (state_q != S_IDLE);
	assign evt_valid = evt_valid_q;

	always_comb begin
		state_d         = state_q;
		cmd             = '0;
		cmd.step        = step_q;
		case (state_q)
			S_IDLE: begin
				if (vtx_valid) begin
					cmd.load_first = 1'b1;
					state_d        = S_ITER1;
				end
			end
			S_ITER1: begin
				cmd.iter = 1'b1;
				if (step_q == LAST_STEP) state_d = S_FIN1;
			end
			S_FIN1: begin
				cmd.fin_first   = 1'b1;
				cmd.load_second = 1'b1;
				state_d         = S_ITER2;
			end
			S_ITER2: begin
				cmd.iter = 1'b1;
				if (step_q == LAST_STEP) state_d = S_FIN2;
			end
			S_FIN2: begin
				cmd.fin_second = 1'b1;
				state_d        = S_CLASS;
			end
			S_CLASS: begin
				if (slot_free) begin
					cmd.classify = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			step_q      <= '0;
			evt_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cmd.load_first || cmd.load_second) step_q <= '0;
			else if (cmd.iter) step_q <= step_q + STEP_W'(1);
			if (cmd.classify) evt_valid_q <= 1'b1;
			else if (!evt_stall) evt_valid_q <= 1'b0;
		end
	end

endmodule

>>> rtl/core/svec_dp.sv
// Datapath of the classifier: shared CORDIC unit, angle registers,
// window tests, opening/closing history and the result register. Uses svec_pkg.
module svec_dp
	import svec_pkg::*;
#(
	parameter int ANGLE_FRAC_BITS = 6
) (
	input  logic      clk,
	input  logic      arst_n,
	input  svec_cmd_t cmd,
	input  svec_in_t  vtx,
	output svec_out_t evt
);

	localparam int ANG_W = 9 + ANGLE_FRAC_BITS;
	localparam int CMP_W = ANG_W + 2;
	localparam int RSH   = ACC_FRAC - ANGLE_FRAC_BITS;

	localparam logic [ANG_W-1:0] A90   = ANG_W'(90 << ANGLE_FRAC_BITS);
	localparam logic [ANG_W-1:0] A180  = ANG_W'(180 << ANGLE_FRAC_BITS);
	localparam logic [ANG_W-1:0] A270  = ANG_W'(270 << ANGLE_FRAC_BITS);
	localparam logic [ANG_W-1:0] AFULL = ANG_W'(360 << ANGLE_FRAC_BITS);

	localparam logic signed [CMP_W-1:0] D90  = CMP_W'(90 << ANGLE_FRAC_BITS);
	localparam logic signed [CMP_W-1:0] D180 = CMP_W'(180 << ANGLE_FRAC_BITS);
	localparam logic signed [CMP_W-1:0] D270 = CMP_W'(270 << ANGLE_FRAC_BITS);

	localparam logic signed [ACC_W-1:0] ZHALF = ACC_W'(1 << (RSH - 1));

	function automatic logic win_in(input logic signed [CMP_W-1:0] f,
	                                input logic signed [CMP_W-1:0] c);
		return (D90 < f && f <= D180) ? (c < D90 || c > f + D180) :
		       (D180 < f && f < D270) ? (f - D180 < c && c < D90) : 1'b0;
	endfunction

	function automatic logic win_side_in(input logic signed [CMP_W-1:0] f,
	                                     input logic signed [CMP_W-1:0] c);
		return (D90 < f && f <= D180) ? (D270 <= c && c < f + D180) :
		       (D180 <= f && f < D270) ? (c < f - D180 || c > D270) : 1'b0;
	endfunction

	function automatic logic win_out(input logic signed [CMP_W-1:0] f,
	                                 input logic signed [CMP_W-1:0] c);
		return (c < D90) ? (c + D180 < f && f < D270) :
		       (c > D270) ? (c - D180 < f && f < D270) : 1'b0;
	endfunction

	function automatic logic win_side_out(input logic signed [CMP_W-1:0] f,
	                                      input logic signed [CMP_W-1:0] c);
		return (c < D90) ? (D90 < f && f < c + D180) :
		       (c > D270) ? (D90 < f && f < c - D180) : 1'b0;
	endfunction

	svec_in_t                item_q;
	logic signed [XY_W-1:0]  x_q, y_q;
	logic signed [ACC_W-1:0] z_q;
	logic                    axis_q;
	logic [ANG_W-1:0]        axis_ang_q;
	logic [ANG_W-1:0]        ang_in_q, ang_out_q;
	logic [1:0]              loc_q;
	svec_out_t               res_q;

	// vector preload
	logic signed [COORD_BITS-1:0] vx, vy;
	logic signed [XY_W-1:0]       ex, ey, px, py;
	logic signed [ACC_W-1:0]      pz;
	logic                         paxis;
	logic [ANG_W-1:0]             pang;

	always_comb begin
		vx    = cmd.load_first ? vtx.in_dx : item_q.out_dx;
		vy    = cmd.load_first ? vtx.in_dy : item_q.out_dy;
		ex    = XY_W'(vx);
		ey    = XY_W'(vy);
		paxis = (vy == '0) || (vx == '0);
		if (vy == '0) pang = (vx < 0) ? A180 : '0;
		else pang = (vy > 0) ? A90 : A270;
		if (ex < 0) begin
			if (ey > 0) begin
				px = ey;
				py = -ex;
				pz = Z90;
			end else begin
				px = -ey;
				py = ex;
				pz = -Z90;
			end
		end else begin
			px = ex;
			py = ey;
			pz = '0;
		end
	end

	// one CORDIC vectoring step
	logic signed [XY_W-1:0]  xs, ys, nx, ny;
	logic signed [ACC_W-1:0] nz, tab;

	always_comb begin
		xs  = x_q >>> cmd.step;
		ys  = y_q >>> cmd.step;
		tab = svec_atan(cmd.step);
		if (!y_q[XY_W-1]) begin
			nx = x_q + ys;
			ny = y_q - xs;
			nz = z_q + tab;
		end else begin
			nx = x_q - ys;
			ny = y_q + xs;
			nz = z_q - tab;
		end
	end

	// wrap and round the accumulator into an angle
	logic signed [ACC_W-1:0] zw1, zw2, zr;
	logic [ANG_W-1:0]        ar, fin_ang;

	always_comb begin
		zw1 = (z_q < 0) ? z_q + Z360 : z_q;
		zw2 = (zw1 >= Z360) ? zw1 - Z360 : zw1;
		zr  = (zw2 + ZHALF) >>> RSH;
		ar  = zr[ANG_W-1:0];
		if (ar >= AFULL) ar = ar - AFULL;
		fin_ang = axis_q ? axis_ang_q : ar;
	end

	// classification
	logic signed [CMP_W-1:0] fi, co;
	logic [2:0]              kind;
	svec_out_t               res_d;
	logic [1:0]              loc_d;

	always_comb begin
		fi = CMP_W'(ang_in_q);
		co = CMP_W'(ang_out_q);
		if (item_q.is_leftmost) kind = item_q.is_boundary ? EV_SIDE_IN : EV_IN;
		else if (win_in(fi, co)) kind = EV_IN;
		else if (win_side_in(fi, co)) kind = EV_SIDE_IN;
		else if (win_out(co, fi)) kind = EV_OUT;
		else if (win_side_out(co, fi)) kind = EV_SIDE_OUT;
		else if (loc_q == LOC_OPENING) kind = EV_CEILING;
		else if (loc_q == LOC_CLOSING) kind = EV_FLOOR;
		else kind = EV_NONE;

		res_d               = '0;
		res_d.event_kind    = kind;
		res_d.from_boundary = item_q.is_boundary;
		loc_d               = loc_q;
		case (kind)
			EV_IN, EV_SIDE_IN: begin
				res_d.floor_source   = SRC_INCOMING;
				res_d.ceiling_source = SRC_OUTGOING;
				loc_d                = LOC_OPENING;
			end
			EV_OUT, EV_SIDE_OUT: begin
				res_d.floor_source   = SRC_OUTGOING;
				res_d.ceiling_source = SRC_INCOMING;
				loc_d                = LOC_CLOSING;
			end
			EV_FLOOR:   res_d.floor_source = SRC_INCOMING;
			EV_CEILING: res_d.ceiling_source = SRC_OUTGOING;
			default:    res_d.from_boundary = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (cmd.load_first) item_q <= vtx;
		if (cmd.load_first || cmd.load_second) begin
			x_q        <= px;
			y_q        <= py;
			z_q        <= pz;
			axis_q     <= paxis;
			axis_ang_q <= pang;
		end else if (cmd.iter) begin
			x_q <= nx;
			y_q <= ny;
			z_q <= nz;
		end
		if (cmd.fin_first) ang_in_q <= fin_ang;
		if (cmd.fin_second) ang_out_q <= fin_ang;
		if (cmd.classify) res_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loc_q <= LOC_NONE;
		end else if (cmd.classify) begin
			loc_q <= loc_d;
		end
	end

	assign evt = res_q;

endmodule

>>> test/svec_event_checker.sv
// Event checker for the sweep vertex event classifier: predicts the event of each
// accepted vertex transaction and compares it with the event channel, in order.
// Depends on svec_pkg.
module svec_event_checker
	import svec_pkg::*;
#(
	parameter int ANGLE_FRAC_BITS = 6
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        vtx_valid,
	input  logic        vtx_stall,
	input  svec_in_t    vtx,
	input  logic        evt_valid,
	input  logic        evt_stall,
	input  svec_out_t   evt,
	output int unsigned fail_count,
	output int unsigned pending
);
	timeunit 1ns;
	timeprecision 1ps;

	// guard bits dropped when the 16-fraction-bit accumulator is rounded
	localparam int GUARD = 16 - ANGLE_FRAC_BITS;

	// atan(2^-i) in degrees, 16 fraction bits
	longint atan_step [0:15] = '{
		2949120, 1740967, 919879, 466945, 234379, 117304, 58666, 29335,
		14668, 7334, 3667, 1833, 917, 458, 229, 115
	};

	svec_out_t   expected_events [$];
	svec_out_t   want;
	logic [1:0]  sweep_side;
	int unsigned n_fail;

	function automatic longint degrees(input longint d);
		return d <<< ANGLE_FRAC_BITS;
	endfunction

	function automatic longint edge_angle(input longint vx, input longint vy);
		longint x, y, z, t, xs, ys, a;
		int     i;
		x = vx;
		y = vy;
		z = 0;
		if (y == 0)
			return (x < 0) ? degrees(180) : 0;
		if (x == 0)
			return (y > 0) ? degrees(90) : degrees(270);
		// fold the left half plane into the right one
		if (x < 0) begin
			t = x;
			if (y > 0) begin
				x = y;
				y = -t;
				z = 90 <<< 16;
			end else begin
				x = -y;
				y = t;
				z = -(90 <<< 16);
			end
		end
		for (i = 0; i < 16; i++) begin
			xs = x >>> i;
			ys = y >>> i;
			if (y >= 0) begin
				x = x + ys;
				y = y - xs;
				z = z + atan_step[i];
			end else begin
				x = x - ys;
				y = y + xs;
				z = z - atan_step[i];
			end
		end
		if (z < 0)
			z = z + (360 <<< 16);
		if (z >= (360 <<< 16))
			z = z - (360 <<< 16);
		a = (z + (1 <<< (GUARD - 1))) >>> GUARD;
		if (a >= degrees(360))
			a = a - degrees(360);
		return a;
	endfunction

	function automatic bit in_window(input longint f, input longint c);
		if (degrees(90) < f && f <= degrees(180))
			return c < degrees(90) || c > f + degrees(180);
		if (degrees(180) < f && f < degrees(270))
			return f - degrees(180) < c && c < degrees(90);
		return 1'b0;
	endfunction

	function automatic bit side_in_window(input longint f, input longint c);
		if (degrees(90) < f && f <= degrees(180))
			return degrees(270) <= c && c < f + degrees(180);
		if (degrees(180) <= f && f < degrees(270))
			return c < f - degrees(180) || c > degrees(270);
		return 1'b0;
	endfunction

	function automatic bit out_window(input longint f, input longint c);
		if (c < degrees(90))
			return c + degrees(180) < f && f < degrees(270);
		if (c > degrees(270))
			return c - degrees(180) < f && f < degrees(270);
		return 1'b0;
	endfunction

	function automatic bit side_out_window(input longint f, input longint c);
		if (c < degrees(90))
			return degrees(90) < f && f < c + degrees(180);
		if (c > degrees(270))
			return degrees(90) < f && f < c - degrees(180);
		return 1'b0;
	endfunction

	// classify one vertex and advance the opening/closing memory
	function automatic svec_out_t predict_event(input svec_in_t v);
		longint    a_in, a_out;
		svec_out_t r;
		a_in  = edge_angle(longint'($signed(v.in_dx)), longint'($signed(v.in_dy)));
		a_out = edge_angle(longint'($signed(v.out_dx)), longint'($signed(v.out_dy)));
		r = '0;
		r.from_boundary = v.is_boundary;
		if (v.is_leftmost)
			r.event_kind = v.is_boundary ? EV_SIDE_IN : EV_IN;
		else if (in_window(a_in, a_out))
			r.event_kind = EV_IN;
		else if (side_in_window(a_in, a_out))
			r.event_kind = EV_SIDE_IN;
		else if (out_window(a_out, a_in))
			r.event_kind = EV_OUT;
		else if (side_out_window(a_out, a_in))
			r.event_kind = EV_SIDE_OUT;
		else if (sweep_side == LOC_OPENING)
			r.event_kind = EV_CEILING;
		else if (sweep_side == LOC_CLOSING)
			r.event_kind = EV_FLOOR;
		else
			r.event_kind = EV_NONE;

		case (r.event_kind)
			EV_IN, EV_SIDE_IN: begin
				r.floor_source   = SRC_INCOMING;
				r.ceiling_source = SRC_OUTGOING;
				sweep_side       = LOC_OPENING;
			end
			EV_OUT, EV_SIDE_OUT: begin
				r.floor_source   = SRC_OUTGOING;
				r.ceiling_source = SRC_INCOMING;
				sweep_side       = LOC_CLOSING;
			end
			EV_FLOOR: begin
				r.floor_source = SRC_INCOMING;
			end
			EV_CEILING: begin
				r.ceiling_source = SRC_OUTGOING;
			end
			default: begin
				r.from_boundary = 1'b0;
			end
		endcase
		return r;
	endfunction

	task automatic check_field(input string name, input logic [2:0] want_v,
			input logic [2:0] got_v);
		if (want_v !== got_v) begin
			$error("%s: expected %0d, got %0d", name, want_v, got_v);
			n_fail++;
		end
	endtask

	// compare the event leaving first, then record the vertex entering
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_events.delete();
			sweep_side = LOC_NONE;
			n_fail     = 0;
			fail_count <= 0;
			pending    <= 0;
		end else begin
			if (evt_valid && !evt_stall) begin
				if (expected_events.size() == 0) begin
					$error("event transaction with no vertex waiting: kind %0d",
						evt.event_kind);
					n_fail++;
				end else begin
					want = expected_events.pop_front();
					check_field("event_kind", want.event_kind, evt.event_kind);
					check_field("floor_source", want.floor_source, evt.floor_source);
					check_field("ceiling_source", want.ceiling_source, evt.ceiling_source);
					check_field("from_boundary", want.from_boundary, evt.from_boundary);
				end
			end
			if (vtx_valid && !vtx_stall)
				expected_events.push_back(predict_event(vtx));
			fail_count <= n_fail;
			pending    <= expected_events.size();
		end
	end

endmodule

>>> test/testbench.sv
// Top of the classifier testbench: clock, reset, vertex stimulus, event sink and verdict.
// Depends on svec_pkg, sweep_vertex_event_classifier and svec_event_checker.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;
	import svec_pkg::*;

	localparam int ANGLE_FRAC  = 6;
	// long receiver hold-off; far more than two vertex times, so the input backs up
	localparam int HOLD_CYCLES = 800;
	// longer than one vertex takes; let a little more pass at the end
	localparam int DRAIN_CYCLES = 60;
	localparam int RANDOM_ITEMS = 950;

	logic        clk          = 1'b0;
	logic        arst_n       = 1'b0;
	logic        vtx_valid    = 1'b0;
	svec_in_t    vtx          = '0;
	logic        evt_stall    = 1'b0;
	logic        vtx_stall;
	logic        evt_valid;
	svec_out_t   evt;
	int unsigned fail_count;
	int unsigned pending;

	// shared between the stimulus and the event sink
	bit          no_idle      = 1'b0;
	bit          hold_request = 1'b0;

	// last outgoing edge, reused as the next incoming edge to walk polygon-like chains
	logic signed [15:0] chain_dx = '0;
	logic signed [15:0] chain_dy = '0;

	sweep_vertex_event_classifier #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC)
	) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.vtx_valid(vtx_valid),
		.vtx_stall(vtx_stall),
		.vtx      (vtx),
		.evt_valid(evt_valid),
		.evt_stall(evt_stall),
		.evt      (evt)
	);

	svec_event_checker #(
		.ANGLE_FRAC_BITS(ANGLE_FRAC)
	) checker_inst (
		.clk       (clk),
		.arst_n    (arst_n),
		.vtx_valid (vtx_valid),
		.vtx_stall (vtx_stall),
		.vtx       (vtx),
		.evt_valid (evt_valid),
		.evt_stall (evt_stall),
		.evt       (evt),
		.fail_count(fail_count),
		.pending   (pending)
	);

	// 20 ns period
	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Gap length for either side: mostly none or short, now and then a long one.
	function automatic int idle_len();
		int r;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 85)
			return $urandom_range(1, 4);
		if (r < 96)
			return $urandom_range(5, 30);
		return $urandom_range(40, 150);
	endfunction

	function automatic svec_in_t vertex_of(input int ix, input int iy, input int ox,
			input int oy, input bit boundary, input bit leftmost);
		svec_in_t v;
		v.in_dx       = 16'(ix);
		v.in_dy       = 16'(iy);
		v.out_dx      = 16'(ox);
		v.out_dy      = 16'(oy);
		v.is_boundary = boundary;
		v.is_leftmost = leftmost;
		return v;
	endfunction

	// One vector component. The modes: full range, tiny, extreme values, on an axis.
	function automatic logic signed [15:0] pick_coord(input int mode);
		case (mode)
			0: return 16'($urandom);
			1: return 16'(int'($urandom_range(0, 8)) - 4);
			2: begin
				case ($urandom_range(0, 5))
					0: return 16'sh8000;
					1: return 16'sh8001;
					2: return -16'sd1;
					3: return 16'sd0;
					4: return 16'sd1;
					default: return 16'sh7fff;
				endcase
			end
			default: return ($urandom_range(0, 1) == 0) ? 16'sd0 : 16'($urandom);
		endcase
	endfunction

	// Random vertex: chained edges, near-reversed edges (the window borders) or free.
	function automatic svec_in_t random_vertex();
		svec_in_t v;
		int       mode, shape;
		mode     = $urandom_range(0, 3);
		shape    = $urandom_range(0, 9);
		v.in_dx  = pick_coord(mode);
		v.in_dy  = pick_coord(mode);
		v.out_dx = pick_coord(mode);
		v.out_dy = pick_coord(mode);
		if (shape < 4) begin
			v.in_dx = chain_dx;
			v.in_dy = chain_dy;
		end else if (shape < 6) begin
			v.out_dx = 16'(-int'($signed(v.in_dx)) + int'($urandom_range(0, 4)) - 2);
			v.out_dy = 16'(-int'($signed(v.in_dy)) + int'($urandom_range(0, 4)) - 2);
		end
		v.is_boundary = 1'($urandom_range(0, 1));
		v.is_leftmost = ($urandom_range(0, 9) == 0);
		chain_dx = v.out_dx;
		chain_dy = v.out_dy;
		return v;
	endfunction

	// Offer one vertex and hold it until the block takes the transaction.
	// Drop valid only when a gap is due, so back-to-back vertices keep it high.
	task automatic offer_vertex(input svec_in_t v);
		int gap;
		gap = no_idle ? 0 : idle_len();
		if (gap > 0) begin
			vtx_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		vtx       <= v;
		vtx_valid <= 1'b1;
		@(posedge clk);
		while (vtx_stall)
			@(posedge clk);
	endtask

	// Event sink: alternate stall stretches and ready stretches; once, on request,
	// hold off for a long stretch while the sender keeps offering vertices.
	initial begin : event_sink
		int n;
		wait (arst_n);
		@(posedge clk);
		forever begin
			n = 0;
			if (hold_request) begin
				hold_request = 1'b0;
				n = HOLD_CYCLES;
			end else if (!no_idle) begin
				n = idle_len();
			end
			if (n > 0) begin
				evt_stall <= 1'b1;
				repeat (n) @(posedge clk);
			end
			evt_stall <= 1'b0;
			repeat (no_idle ? 1 : $urandom_range(1, 12)) @(posedge clk);
		end
	end

	initial begin : stimulus
		svec_in_t directed [$];
		int       k;

		// Hold reset, then release it at a rising edge.
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Nothing opened or closed yet: no match gives no event, boundary flag cleared.
		directed.push_back(vertex_of(1, 0, 1, 0, 1'b1, 1'b0));
		// Zero vectors read as angle 0.
		directed.push_back(vertex_of(0, 0, 0, 0, 1'b0, 1'b0));
		// Leftmost boundary vertex: forced side-in.
		directed.push_back(vertex_of(3, -7, -2, 5, 1'b1, 1'b1));
		// After an opening, no match gives a ceiling.
		directed.push_back(vertex_of(0, 0, 0, 0, 1'b1, 1'b0));
		// Out, then a floor after the closing.
		directed.push_back(vertex_of(1, 1, -1, -2, 1'b0, 1'b0));
		directed.push_back(vertex_of(1, 0, 1, 0, 1'b1, 1'b0));
		// Leftmost obstacle vertex: forced in.
		directed.push_back(vertex_of(5, 5, 5, -5, 1'b0, 1'b1));
		// In, side-in and side-out windows.
		directed.push_back(vertex_of(-1, 1, 1, 0, 1'b1, 1'b0));
		directed.push_back(vertex_of(-1, 1, 0, -1, 1'b0, 1'b0));
		directed.push_back(vertex_of(1, 1, -1, 0, 1'b1, 1'b0));
		// Floor angle exactly 180, ceiling at 0 and at exactly 270.
		directed.push_back(vertex_of(-5, 0, 1, 0, 1'b0, 1'b0));
		directed.push_back(vertex_of(-5, 0, 0, -5, 1'b1, 1'b0));
		// Exactly reversed edges sit on the window borders.
		directed.push_back(vertex_of(-1, -1, 1, 1, 1'b1, 1'b0));
		directed.push_back(vertex_of(0, -3, 3, 0, 1'b0, 1'b0));
		// Extremes of the coordinate range, on and off the axes.
		directed.push_back(vertex_of(-32768, -32768, 32767, 32767, 1'b0, 1'b0));
		directed.push_back(vertex_of(32767, -32768, -32768, 32767, 1'b1, 1'b0));
		directed.push_back(vertex_of(-32768, 0, 0, -32768, 1'b0, 1'b0));
		directed.push_back(vertex_of(0, 32767, 32767, 0, 1'b1, 1'b0));
		directed.push_back(vertex_of(-32768, 1, 1, -32768, 1'b0, 1'b0));
		directed.push_back(vertex_of(-32768, -1, -1, 32767, 1'b1, 1'b0));
		directed.push_back(vertex_of(-1, -1, 1, -1, 1'b0, 1'b0));
		directed.push_back(vertex_of(2, -1, -1, -3, 1'b1, 1'b0));
		directed.push_back(vertex_of(-32768, -32768, -32768, -32768, 1'b1, 1'b1));
		foreach (directed[i])
			offer_vertex(directed[i]);

		// Random part. Ask for the long hold-off right away so the block backs up,
		// then run a stretch with no idling on either side.
		hold_request = 1'b1;
		for (k = 0; k < RANDOM_ITEMS; k++) begin
			no_idle = (k >= 350 && k < 500);
			offer_vertex(random_vertex());
		end
		no_idle = 1'b0;
		vtx_valid <= 1'b0;

		// Wait for the last events, then a little longer to catch strays.
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (fail_count == 0)
			$display("SCOREBOARD CLEAN");
		else
			$display("SCOREBOARD MISMATCH");
		$finish;
	end

	// Give up if the run never finishes; a correct run ends long before this fires.
	initial begin : watchdog
		#30_000_000;
		$display("SCOREBOARD MISMATCH");
		$finish;
	end

endmodule

>>> sweep_vertex_event_classifier.f
+incdir+rtl/core
rtl/core/svec_pkg.sv
rtl/core/svec_ctrl.sv
rtl/core/svec_dp.sv
rtl/core/sweep_vertex_event_classifier.sv
test/svec_event_checker.sv
test/testbench.sv
